// ===== design/accumulator_cpu_step_defines.svh =====
// Assertion macros shared by the checker of accumulator_cpu_step.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef ACCUMULATOR_CPU_STEP_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ACS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/acs_pkg.sv =====
// Package for accumulator_cpu_step: codes, microcode word layout and the microprogram.
// No dependencies.
package acs_pkg;

   localparam int MEMORY_WORDS_DEF = 128;
   localparam int WORD_W           = 13;

   // request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_STEP  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // result events
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_PRINT = 3'd1;
   localparam logic [2:0] EV_PORT  = 3'd2;
   localparam logic [2:0] EV_STOP  = 3'd3;
   localparam logic [2:0] EV_FAULT = 3'd4;

   // fault kinds
   localparam logic [1:0] FK_NONE    = 2'd0;
   localparam logic [1:0] FK_OPCODE  = 2'd1;
   localparam logic [1:0] FK_ADDRESS = 2'd2;
   localparam logic [1:0] FK_RANGE   = 2'd3;

   // instruction opcodes
   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_HALT    = 5'd1;
   localparam logic [4:0] OP_PRINT   = 5'd2;
   localparam logic [4:0] OP_NOP_ARG = 5'd3;
   localparam logic [4:0] OP_LDC     = 5'd4;
   localparam logic [4:0] OP_LDM     = 5'd5;
   localparam logic [4:0] OP_STORE   = 5'd6;
   localparam logic [4:0] OP_ADD     = 5'd7;
   localparam logic [4:0] OP_SUB     = 5'd8;
   localparam logic [4:0] OP_JMP     = 5'd9;
   localparam logic [4:0] OP_CEQ     = 5'd10;
   localparam logic [4:0] OP_JC      = 5'd11;
   localparam logic [4:0] OP_CGT     = 5'd12;
   localparam logic [4:0] OP_CLT     = 5'd13;
   localparam logic [4:0] OP_NEG     = 5'd14;
   localparam logic [4:0] OP_AND     = 5'd15;
   localparam logic [4:0] OP_OUT     = 5'd18;

   typedef logic [3:0] upc_type;

   // microprogram step addresses
   localparam upc_type U_IDLE    = 4'd0;
   localparam upc_type U_LOAD    = 4'd1;
   localparam upc_type U_START   = 4'd2;
   localparam upc_type U_NOP     = 4'd3;
   localparam upc_type U_STEP    = 4'd4;
   localparam upc_type U_PCCHK   = 4'd5;
   localparam upc_type U_DECODE  = 4'd6;
   localparam upc_type U_EXEC    = 4'd7;
   localparam upc_type U_HALTED  = 4'd8;
   localparam upc_type U_FFAULT  = 4'd9;

   typedef enum logic [2:0] {
      A_NONE,
      A_LOAD,
      A_START,
      A_FETCH,
      A_DECODE,
      A_EXEC,
      A_STOP,
      A_FAULT_ADDR
   } act_type;

   typedef enum logic {
      C_STOPPED,
      C_PC_OOR
   } cond_type;

   typedef enum logic [1:0] {
      SEQ_WAIT,
      SEQ_NEXT,
      SEQ_BRANCH,
      SEQ_DONE
   } seq_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      seq_type  seq;
      upc_type  target;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      logic    accept;
      act_type act;
      logic    finish;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic stopped;
      logic pc_oor;
   } sts_type;

   // values the result word is loaded from
   typedef struct packed {
      logic [2:0] ev;
      logic [7:0] acc;
      logic [1:0] fault;
      logic [7:0] pc;
   } res_type;

   function automatic ucode_type ucode_rom(input upc_type u);
      ucode_type w;
      case (u)
         U_IDLE:   w = '{A_NONE,       C_STOPPED, SEQ_WAIT,   U_IDLE};
         U_LOAD:   w = '{A_LOAD,       C_STOPPED, SEQ_DONE,   U_IDLE};
         U_START:  w = '{A_START,      C_STOPPED, SEQ_DONE,   U_IDLE};
         U_NOP:    w = '{A_NONE,       C_STOPPED, SEQ_DONE,   U_IDLE};
         U_STEP:   w = '{A_FETCH,      C_STOPPED, SEQ_BRANCH, U_HALTED};
         U_PCCHK:  w = '{A_NONE,       C_PC_OOR,  SEQ_BRANCH, U_FFAULT};
         U_DECODE: w = '{A_DECODE,     C_STOPPED, SEQ_NEXT,   U_IDLE};
         U_EXEC:   w = '{A_EXEC,       C_STOPPED, SEQ_DONE,   U_IDLE};
         U_HALTED: w = '{A_STOP,       C_STOPPED, SEQ_DONE,   U_IDLE};
         U_FFAULT: w = '{A_FAULT_ADDR, C_STOPPED, SEQ_DONE,   U_IDLE};
         default:  w = '{A_NONE,       C_STOPPED, SEQ_DONE,   U_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== design/accumulator_cpu_step.sv =====
// 8-bit accumulator machine with a MEMORY_WORDS-word program store (5-bit opcode, 8-bit
// operand); a request loads a word, starts the machine or executes one instruction, and
// each request returns one result word. Timing is set by the microprogram and by the
// single read port of the store, which serves the instruction fetch and the operand read
// one after the other: an execute runs the fetch, range check, decode and execute steps;
// a stopped machine ends in the stop step, a fetch beyond the store in the fault step;
// load, start and unused modes run only their own step. The result sits in an output
// register, so the next request is taken while a result is still stalled. Store words
// read as zero until written; reset clears all per-word valid bits at once.
module accumulator_cpu_step
   import acs_pkg::*;
#(
   parameter int MEMORY_WORDS = MEMORY_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [6:0] req_address,
   input  logic [4:0] req_load_opcode,
   input  logic [7:0] req_load_operand,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_accumulator_value,
   output logic [1:0] rsp_fault_kind,
   output logic [7:0] rsp_next_pc
);

   ctl_type ctl;
   sts_type sts;
   res_type res;
   logic    out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   res_type    rsp_res_ff, rsp_res_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   acs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .out_free  (out_free),
      .sts       (sts),
      .ctl       (ctl)
   );

   acs_dp #(
      .MEMORY_WORDS (MEMORY_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_address      (req_address),
      .req_load_opcode  (req_load_opcode),
      .req_load_operand (req_load_operand),
      .sts              (sts),
      .res              (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_res         = rsp_res_ff.ev;
   assign rsp_accumulator_value = rsp_res_ff.acc;
   assign rsp_fault_kind        = rsp_res_ff.fault;
   assign rsp_next_pc           = rsp_res_ff.pc;

endmodule

// ===== design/acs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module acs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/acs_seq.sv =====
// Microcode sequencer: step counter, control store lookup, dispatch and branches.
// Depends on acs_pkg.
module acs_seq
   import acs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_stall,
   input  logic       out_free,
   input  sts_type    sts,
   output ctl_type    ctl
);

   upc_type   upc_ff, upc_in;
   ucode_type uw;
   logic      accept;
   logic      adv;
   logic      cond_true;

   assign uw = ucode_rom(upc_ff);

   // outputs of the current step
   always_comb begin
      req_stall = (uw.seq != SEQ_WAIT);
      accept    = req_valid && !req_stall;
      // a step ending in a result waits for the output word to free up
      adv       = (uw.seq != SEQ_DONE) || out_free;
      ctl.accept = accept;
      ctl.act    = adv ? uw.act : A_NONE;
      ctl.finish = (uw.seq == SEQ_DONE) && out_free;
   end

   // next step
   always_comb begin
      case (uw.cond)
         C_STOPPED: cond_true = sts.stopped;
         C_PC_OOR:  cond_true = sts.pc_oor;
         default:   cond_true = 1'b0;
      endcase

      upc_in = upc_ff;
      case (uw.seq)
         SEQ_WAIT: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD:  upc_in = U_LOAD;
                  MODE_STEP:  upc_in = U_STEP;
                  MODE_START: upc_in = U_START;
                  default:    upc_in = U_NOP;
               endcase
            end
         end
         SEQ_NEXT:   upc_in = upc_ff + 4'd1;
         SEQ_BRANCH: upc_in = cond_true ? uw.target : upc_ff + 4'd1;
         SEQ_DONE:   upc_in = out_free ? U_IDLE : upc_ff;
         default:    upc_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== design/acs_dp.sv =====
// Datapath: machine registers, program store with per-word valid bits, execute logic.
// Depends on acs_pkg and acs_ram.
module acs_dp
   import acs_pkg::*;
#(
   parameter int MEMORY_WORDS = MEMORY_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  ctl_type    ctl,
   input  logic [6:0] req_address,
   input  logic [4:0] req_load_opcode,
   input  logic [7:0] req_load_operand,
   output sts_type    sts,
   output res_type    res
);

   localparam int         AW     = $clog2(MEMORY_WORDS);
   localparam logic [8:0] MW_LIM = 9'(MEMORY_WORDS);

   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  pc_ff, pc_in;
   logic        cond_ff, cond_in;
   logic        stopped_ff, stopped_in;
   logic [1:0]  fault_ff, fault_in;
   logic [2:0]  ev_ff, ev_in;
   logic [4:0]  op_ff, op_in;
   logic [7:0]  arg_ff, arg_in;
   logic [6:0]  addr_ff, addr_in;
   logic [4:0]  lop_ff, lop_in;
   logic [7:0]  lval_ff, lval_in;
   logic [MEMORY_WORDS-1:0] valid_ff, valid_in;
   logic        rd_valid_ff, rd_valid_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_idx, rd_idx;
   logic [WORD_W-1:0] wr_data, rd_data, word;

   logic [8:0] pc_w, arg_w, dec_w, ld_w;
   logic       pc_oor, arg_oor, dec_oor, ld_oor;
   logic [7:0] m;
   logic [8:0] sum;

   acs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEMORY_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   // never-written words read as zero
   assign word = rd_valid_ff ? rd_data : '0;
   assign m    = word[7:0];

   assign pc_w  = {1'b0, pc_ff};
   assign arg_w = {1'b0, arg_ff};
   assign dec_w = {1'b0, word[7:0]};
   assign ld_w  = {2'b00, addr_ff};

   assign pc_oor  = pc_w >= MW_LIM;
   assign arg_oor = arg_w >= MW_LIM;
   assign dec_oor = dec_w >= MW_LIM;
   assign ld_oor  = ld_w >= MW_LIM;

   assign sum = {1'b0, acc_ff} + {1'b0, m};

   always_comb begin
      acc_in     = acc_ff;
      pc_in      = pc_ff;
      cond_in    = cond_ff;
      stopped_in = stopped_ff;
      fault_in   = fault_ff;
      ev_in      = ctl.accept ? EV_NONE : ev_ff;
      op_in      = op_ff;
      arg_in     = arg_ff;
      addr_in    = ctl.accept ? req_address : addr_ff;
      lop_in     = ctl.accept ? req_load_opcode : lop_ff;
      lval_in    = ctl.accept ? req_load_operand : lval_ff;
      wr_en      = 1'b0;
      wr_idx     = ld_w[AW-1:0];
      wr_data    = {lop_ff, lval_ff};
      rd_en      = 1'b0;
      rd_idx     = pc_w[AW-1:0];

      case (ctl.act)
         A_LOAD: begin
            wr_en = !ld_oor;
         end
         A_START: begin
            pc_in      = {1'b0, addr_ff};
            stopped_in = 1'b0;
            fault_in   = FK_NONE;
         end
         A_FETCH: begin
            rd_en = !pc_oor;
         end
         A_DECODE: begin
            op_in  = word[12:8];
            arg_in = word[7:0];
            pc_in  = pc_ff + 8'd1;
            // operand read issued early; unused by opcodes without one
            rd_en  = !dec_oor;
            rd_idx = dec_w[AW-1:0];
         end
         A_EXEC: begin
            case (op_ff)
               OP_NOP, OP_NOP_ARG: ;
               OP_HALT: begin
                  stopped_in = 1'b1;
                  ev_in      = EV_STOP;
               end
               OP_PRINT: ev_in = EV_PRINT;
               OP_OUT:   ev_in = EV_PORT;
               OP_LDC:   acc_in = arg_ff;
               OP_JMP:   pc_in = arg_ff;
               OP_JC: begin
                  if (cond_ff) begin
                     pc_in = arg_ff;
                  end
               end
               OP_NEG:   acc_in = 8'd0 - acc_ff;
               OP_STORE: begin
                  if (arg_oor) begin
                     fault_in   = FK_ADDRESS;
                     stopped_in = 1'b1;
                     ev_in      = EV_FAULT;
                  end else begin
                     wr_en   = 1'b1;
                     wr_idx  = arg_w[AW-1:0];
                     wr_data = {5'd0, acc_ff};
                  end
               end
               OP_LDM, OP_ADD, OP_SUB, OP_CEQ, OP_CGT, OP_CLT, OP_AND: begin
                  if (arg_oor) begin
                     fault_in   = FK_ADDRESS;
                     stopped_in = 1'b1;
                     ev_in      = EV_FAULT;
                  end else begin
                     case (op_ff)
                        OP_LDM: acc_in = m;
                        OP_ADD: begin
                           if (sum[8]) begin
                              fault_in   = FK_RANGE;
                              stopped_in = 1'b1;
                              ev_in      = EV_FAULT;
                           end else begin
                              acc_in = sum[7:0];
                           end
                        end
                        OP_SUB: begin
                           if (m > acc_ff) begin
                              fault_in   = FK_RANGE;
                              stopped_in = 1'b1;
                              ev_in      = EV_FAULT;
                           end else begin
                              acc_in = acc_ff - m;
                           end
                        end
                        OP_CEQ:  cond_in = (acc_ff == m);
                        OP_CGT:  cond_in = (acc_ff > m);
                        OP_CLT:  cond_in = (acc_ff < m);
                        default: acc_in = acc_ff & m;
                     endcase
                  end
               end
               default: begin
                  fault_in   = FK_OPCODE;
                  stopped_in = 1'b1;
                  ev_in      = EV_FAULT;
               end
            endcase
         end
         A_STOP: begin
            ev_in = EV_STOP;
         end
         A_FAULT_ADDR: begin
            // fetch beyond the store: counter stays put
            fault_in   = FK_ADDRESS;
            stopped_in = 1'b1;
            ev_in      = EV_FAULT;
         end
         default: ;
      endcase

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      rd_valid_in = rd_en ? valid_ff[rd_idx] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= 8'd0;
         pc_ff      <= 8'd0;
         cond_ff    <= 1'b0;
         stopped_ff <= 1'b1;
         fault_ff   <= FK_NONE;
         ev_ff      <= EV_NONE;
         valid_ff   <= '0;
      end else begin
         acc_ff     <= acc_in;
         pc_ff      <= pc_in;
         cond_ff    <= cond_in;
         stopped_ff <= stopped_in;
         fault_ff   <= fault_in;
         ev_ff      <= ev_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      arg_ff      <= arg_in;
      addr_ff     <= addr_in;
      lop_ff      <= lop_in;
      lval_ff     <= lval_in;
      rd_valid_ff <= rd_valid_in;
   end

   assign sts.stopped = stopped_ff;
   assign sts.pc_oor  = pc_oor;

   assign res.ev    = ev_in;
   assign res.acc   = acc_in;
   assign res.fault = fault_in;
   assign res.pc    = pc_in;

endmodule

// ===== design/acs_checker.sv =====
// Port-level checker for accumulator_cpu_step, bound to the top level.
// Depends on acs_pkg and accumulator_cpu_step_defines.svh.
`include "accumulator_cpu_step_defines.svh"

module acs_checker
   import acs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_accumulator_value,
   input logic [1:0] rsp_fault_kind,
   input logic [7:0] rsp_next_pc
);

   // stalled result word holds
   `ACS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_res) && $stable(rsp_accumulator_value) && $stable(rsp_fault_kind) && $stable(rsp_next_pc), "rsp word changed while stalled")

   // one request in work at a time
   `ACS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "req taken while previous one still in work")

   `ACS_ASSERT_SAME(a_fault_latched, rsp_valid && (rsp_event_res == EV_FAULT), rsp_fault_kind != FK_NONE, "fault event without fault kind")

   // a running machine never carries a latched fault
   `ACS_ASSERT_SAME(a_run_clean, rsp_valid && (rsp_event_res == EV_PRINT || rsp_event_res == EV_PORT), rsp_fault_kind == FK_NONE, "output event with fault latched")

endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (.*);
